### sv/assert_macros.svh
// assertion helpers for the rtl modules (included by lkps_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

### sv/lkps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkps_pkg
// shared constants, command codes and types of the log kernel potential sum
// ----------------------------------------------------------------------------
package lkps_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 25;
    localparam int MANT_BITS  = 30;
    localparam int CNT_W      = $clog2(FRAC_BITS);

    localparam logic [30:0] LN2_HALF_Q32 = 31'd1488522236;
    localparam logic [30:0] INV_PI_Q32   = 31'd1367130551;

    // register indexes
    localparam logic [2:0] REG_WIN_XL    = 3'd0;
    localparam logic [2:0] REG_WIN_XH    = 3'd1;
    localparam logic [2:0] REG_WIN_YL    = 3'd2;
    localparam logic [2:0] REG_WIN_YH    = 3'd3;
    localparam logic [2:0] REG_AREA_IN   = 3'd4;
    localparam logic [2:0] REG_AREA_OUT  = 3'd5;

    typedef logic [3:0] op_t;

    // datapath operations
    localparam op_t OP_NONE  = 4'd0;
    localparam op_t OP_LOAD  = 4'd1;
    localparam op_t OP_DIFF  = 4'd2;
    localparam op_t OP_SQX   = 4'd3;
    localparam op_t OP_SQY   = 4'd4;
    localparam op_t OP_NORM  = 4'd5;
    localparam op_t OP_LOG   = 4'd6;
    localparam op_t OP_LN    = 4'd7;
    localparam op_t OP_KAP   = 4'd8;
    localparam op_t OP_AREA  = 4'd9;
    localparam op_t OP_ACC   = 4'd10;
    localparam op_t OP_OUTHI = 4'd11;
    localparam op_t OP_OUTLO = 4'd12;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic last;
    } stat_t;

    typedef struct packed {
        logic signed [23:0] win_xl;
        logic signed [23:0] win_xh;
        logic signed [23:0] win_yl;
        logic signed [23:0] win_yh;
        logic [31:0]        area_in;
        logic [31:0]        area_out;
    } cfg_t;

endpackage

### sv/lkps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkps_ctrl
// sequencer: walks one source transaction through the datapath steps
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkps_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  lkps_pkg::stat_t stat,
    output lkps_pkg::cmd_t  cmd
);
    import lkps_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_SQX   = 4'd2;
    localparam logic [3:0] S_SQY   = 4'd3;
    localparam logic [3:0] S_NORM  = 4'd4;
    localparam logic [3:0] S_LOG   = 4'd5;
    localparam logic [3:0] S_LN    = 4'd6;
    localparam logic [3:0] S_KAP   = 4'd7;
    localparam logic [3:0] S_AREA  = 4'd8;
    localparam logic [3:0] S_ACC   = 4'd9;
    localparam logic [3:0] S_OUTHI = 4'd10;
    localparam logic [3:0] S_OUTLO = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.op       = OP_NONE;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                cmd.op = OP_DIFF;
                if (stat.skip) begin
                    state_next = stat.last ? S_OUTHI : S_IDLE;
                end else begin
                    state_next = S_SQX;
                end
            end
            S_SQX: begin
                cmd.op     = OP_SQX;
                state_next = S_SQY;
            end
            S_SQY: begin
                cmd.op     = OP_SQY;
                state_next = S_NORM;
            end
            S_NORM: begin
                cmd.op     = OP_NORM;
                cnt_next   = '0;
                state_next = S_LOG;
            end
            S_LOG: begin
                cmd.op   = OP_LOG;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_LN;
                end
            end
            S_LN: begin
                cmd.op     = OP_LN;
                state_next = S_KAP;
            end
            S_KAP: begin
                cmd.op     = OP_KAP;
                state_next = S_AREA;
            end
            S_AREA: begin
                cmd.op     = OP_AREA;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.op     = OP_ACC;
                state_next = stat.last ? S_OUTHI : S_IDLE;
            end
            S_OUTHI: begin
                cmd.op     = OP_OUTHI;
                state_next = S_OUTLO;
            end
            S_OUTLO: begin
                // wait here until the output register is free
                if (out_free) begin
                    cmd.op       = OP_OUTLO;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ASSERT_CLK(a_cnt_only_in_log, (state_reg != S_LOG) |-> (cnt_reg == '0), "log count stray")
    `ASSERT_CLK(a_out_load_free, (cmd.op == OP_OUTLO) |-> out_free, "result overwritten")
    `ASSERT_CLK(a_accept_starts, (s_valid && s_ready) |=> (state_reg == S_DIFF), "bad start")

endmodule

### sv/lkps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkps_dp
// datapath: distance, iterative log2, scaling, saturating sum, 1/pi output
// ----------------------------------------------------------------------------
module lkps_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  lkps_pkg::cmd_t      cmd,
    output lkps_pkg::stat_t     stat,
    input  lkps_pkg::cfg_t      cfg,
    input  logic                s_first_of_target,
    input  logic signed [23:0]  s_target_x,
    input  logic signed [23:0]  s_target_y,
    input  logic signed [23:0]  s_source_x,
    input  logic signed [23:0]  s_source_y,
    input  logic [19:0]         s_source_kappa,
    input  logic                s_from_outer_map,
    input  logic                s_last_source,
    output logic signed [63:0]  m_potential,
    output logic                m_saturated
);
    import lkps_pkg::*;

    localparam int D2_W = 2 * COORD_BITS;
    localparam int E_W  = $clog2(D2_W);
    localparam int R_W  = E_W + FRAC_BITS;

    // latched transaction
    logic signed [23:0]           sx_reg, sy_reg;
    logic [19:0]                  kappa_reg;
    logic                         outer_reg, last_reg, skip_reg;
    logic signed [COORD_BITS-1:0] htx_reg, hty_reg;
    // working registers
    logic [COORD_BITS-1:0]        ax_reg, ay_reg;
    logic [D2_W-1:0]              sq_reg, d2_reg;
    logic [E_W-1:0]               e_reg;
    logic [MANT_BITS:0]           m_reg;
    logic [FRAC_BITS-1:0]         frac_reg;
    logic                         neg_reg;
    logic [20:0]                  lnmag_reg;
    logic [25:0]                  p1_reg;
    logic [49:0]                  p2_reg;
    logic signed [63:0]           acc_reg;
    logic                         ovf_reg;
    logic [62:0]                  hiprod_reg;
    logic [31:0]                  lo_reg;
    logic                         oneg_reg;
    logic signed [63:0]           pot_reg;
    logic                         sat_reg;

    logic                          skip_in;
    logic signed [COORD_BITS-1:0]  dx, dy;
    logic [D2_W-1:0]               d2f;
    logic [E_W-1:0]                e_find;
    logic [D2_W+MANT_BITS-1:0]     norm_sh;
    logic [2*MANT_BITS+1:0]        msq;
    logic [MANT_BITS+1:0]          mtop;
    logic signed [R_W:0]           l2;
    logic [R_W-1:0]                l2mag;
    logic [53:0]                   lnprod;
    logic [41:0]                   kprod;
    logic [58:0]                   aprod;
    logic [31:0]                   area_sel;
    logic signed [64:0]            term, acc_sum;
    logic [63:0]                   amag;
    logic [63:0]                   loprod, q;

    assign skip_in = s_from_outer_map
                  && (s_source_x >= cfg.win_xl) && (s_source_x <= cfg.win_xh)
                  && (s_source_y >= cfg.win_yl) && (s_source_y <= cfg.win_yh);

    always_comb begin
        dx = {sx_reg[23], sx_reg} - htx_reg;
        dy = {sy_reg[23], sy_reg} - hty_reg;
        d2f = (d2_reg == '0) ? D2_W'(1) : d2_reg;
        e_find = '0;
        for (int i = 0; i < D2_W; i++) begin
            if (d2f[i]) e_find = E_W'(i);
        end
        norm_sh = {d2f, {MANT_BITS{1'b0}}} >> e_find;
        msq     = m_reg * m_reg;
        mtop    = msq[2*MANT_BITS+1:MANT_BITS];
        l2      = $signed({1'b0, e_reg, frac_reg}) - $signed((R_W+1)'(2 * FRAC_BITS * 65536));
        l2mag   = l2[R_W] ? R_W'(-l2) : R_W'(l2);
        lnprod  = 54'(l2mag) * 54'(LN2_HALF_Q32) + 54'(64'h8000_0000);
        kprod   = 42'(kappa_reg) * 42'(lnmag_reg) + 42'(1 << (FRAC_BITS - 1));
        area_sel = outer_reg ? cfg.area_out : cfg.area_in;
        aprod   = 59'(p1_reg) * 59'(area_sel) + 59'd128;
        term    = neg_reg ? -$signed({15'd0, p2_reg}) : $signed({15'd0, p2_reg});
        acc_sum = $signed({acc_reg[63], acc_reg}) + term;
        amag    = acc_reg[63] ? (64'd0 - 64'(acc_reg)) : 64'(acc_reg);
        loprod  = 64'(lo_reg) * 64'(INV_PI_Q32) + 64'h8000_0000;
        q       = 64'(hiprod_reg) + {32'd0, loprod[63:32]};
    end

    // control state of the running sum, with its overflow flag and the latched target
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            htx_reg <= '0;
            hty_reg <= '0;
        end else begin
            if (cmd.op == OP_LOAD && s_first_of_target) begin
                acc_reg <= '0;
                ovf_reg <= 1'b0;
                htx_reg <= COORD_BITS'(s_target_x);
                hty_reg <= COORD_BITS'(s_target_y);
            end else if (cmd.op == OP_ACC) begin
                if (acc_sum[64] != acc_sum[63]) begin
                    acc_reg <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    ovf_reg <= 1'b1;
                end else begin
                    acc_reg <= acc_sum[63:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                sx_reg    <= s_source_x;
                sy_reg    <= s_source_y;
                kappa_reg <= s_source_kappa;
                outer_reg <= s_from_outer_map;
                last_reg  <= s_last_source;
                skip_reg  <= skip_in;
            end
            OP_DIFF: begin
                ax_reg <= dx[COORD_BITS-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
                ay_reg <= dy[COORD_BITS-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
            end
            OP_SQX: sq_reg <= D2_W'(ax_reg) * D2_W'(ax_reg);
            OP_SQY: d2_reg <= sq_reg + D2_W'(ay_reg) * D2_W'(ay_reg);
            OP_NORM: begin
                e_reg    <= e_find;
                m_reg    <= norm_sh[MANT_BITS:0];
                frac_reg <= '0;
            end
            OP_LOG: begin
                m_reg    <= mtop[MANT_BITS+1] ? mtop[MANT_BITS+1:1] : mtop[MANT_BITS:0];
                frac_reg <= {frac_reg[FRAC_BITS-2:0], mtop[MANT_BITS+1]};
            end
            OP_LN: begin
                neg_reg   <= l2[R_W];
                lnmag_reg <= lnprod[52:32];
            end
            OP_KAP:  p1_reg <= kprod[41:16];
            OP_AREA: p2_reg <= aprod[57:8];
            OP_OUTHI: begin
                hiprod_reg <= 63'(amag[63:32]) * 63'(INV_PI_Q32);
                lo_reg     <= amag[31:0];
                oneg_reg   <= acc_reg[63];
            end
            OP_OUTLO: begin
                pot_reg <= oneg_reg ? $signed(64'd0 - q) : $signed(q);
                sat_reg <= ovf_reg;
            end
            default: begin
            end
        endcase
    end

    assign stat.skip   = skip_reg;
    assign stat.last   = last_reg;
    assign m_potential = pot_reg;
    assign m_saturated = sat_reg;

endmodule

### sv/log_kernel_potential_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_kernel_potential_sum
// direct-sum 2d log-kernel potential at one target point
// ----------------------------------------------------------------------------
// usage:
//   s_* channel (valid/ready) streams source cells; first_of_target clears
//   the sum and latches the target, last_source closes the target and
//   produces one m_* transaction (potential / pi, saturation flag)
//   cfg_wr_en / cfg_index / cfg_wr_data write the window and area registers
//   while the block is idle; writes take effect at once, no read-back
// sequence:
//   a source is accepted, then runs difference, two squares, normalize,
//   the shared log2 squaring step once per fraction bit, three scaling
//   multiplies, accumulate; a window-skipped cell ends after the difference
//   a last source then runs the 1/pi multiply as a high-half and a low-half
//   step and registers its result; s_ready is high only between sources
//   the log2 loop through one 31x31 multiplier sets the rate
// reset / stall:
//   aresetn (synchronous, low) clears the sum, target, overflow flag,
//   sequencer state, output valid and configuration registers
//   a waiting result sits in the output register; the next source is still
//   taken, and only a following result waits for m_ready
// ----------------------------------------------------------------------------
module log_kernel_potential_sum (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wr_data,
    // source transactions
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_first_of_target,
    input  logic signed [23:0] s_target_x,
    input  logic signed [23:0] s_target_y,
    input  logic signed [23:0] s_source_x,
    input  logic signed [23:0] s_source_y,
    input  logic [19:0]        s_source_kappa,
    input  logic               s_from_outer_map,
    input  logic               s_last_source,
    // result transactions
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_potential,
    output logic               m_saturated
);
    import lkps_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    // configuration registers; the user must write them only while idle, which the block does not enforce
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WIN_XL:   cfg_reg.win_xl   <= $signed(cfg_wr_data[23:0]);
                REG_WIN_XH:   cfg_reg.win_xh   <= $signed(cfg_wr_data[23:0]);
                REG_WIN_YL:   cfg_reg.win_yl   <= $signed(cfg_wr_data[23:0]);
                REG_WIN_YH:   cfg_reg.win_yh   <= $signed(cfg_wr_data[23:0]);
                REG_AREA_IN:  cfg_reg.area_in  <= cfg_wr_data;
                REG_AREA_OUT: cfg_reg.area_out <= cfg_wr_data;
                default: begin
                    // unused indexes are ignored
                end
            endcase
        end
    end

    // sequencer
    lkps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic
    lkps_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .cfg               (cfg_reg),
        .s_first_of_target (s_first_of_target),
        .s_target_x        (s_target_x),
        .s_target_y        (s_target_y),
        .s_source_x        (s_source_x),
        .s_source_y        (s_source_y),
        .s_source_kappa    (s_source_kappa),
        .s_from_outer_map  (s_from_outer_map),
        .s_last_source     (s_last_source),
        .m_potential       (m_potential),
        .m_saturated       (m_saturated)
    );

endmodule
